// ===== sv/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, sizes and saturation helpers for the cascaded biquad filter.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int MAX_SECTIONS   = 4;
  localparam int COEF_FRAC_BITS = 14;
  localparam int STATE_WIDTH    = 24;

  localparam int SAMPLE_W   = 12;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 5;
  localparam int OUT_W      = 24;
  localparam int NS_W       = 3;

  localparam int FO_BASE   = 5 * MAX_SECTIONS;
  localparam int NUM_COEFS = FO_BASE + 3;
  localparam int COEF_AW   = $clog2(NUM_COEFS);
  localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // full product, and accumulator wide enough for x plus three scaled terms
  localparam int PROD_W = STATE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W - COEF_FRAC_BITS + 2;
  localparam int SAT_W  = ((STATE_WIDTH > OUT_W) ? STATE_WIDTH : OUT_W) + 1;
  localparam int MCNT_W = $clog2(COEF_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SECTIONS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ORDER  = CFG_IDX_W'(1);

  typedef logic signed [STATE_WIDTH-1:0] state_word_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [SAT_W-1:0]       sat_word_t;

  localparam acc_t ST_HI = {{(ACC_W - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
  localparam acc_t ST_LO = ~ST_HI;
  localparam sat_word_t OUT_HI = {{(SAT_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam sat_word_t OUT_LO = ~OUT_HI;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_COEF
  } cmd_t;

  // a1,a2,b0,b1,b2 within a section
  typedef enum logic [2:0] {
    OP_A1,
    OP_A2,
    OP_B0,
    OP_B1,
    OP_B2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_MID,
    ST_END,
    ST_OUT
  } state_t;

  typedef struct packed {
    cmd_t                         cmd;
    logic signed [SAMPLE_W-1:0]   sample;
    logic [COEF_IDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0]     coef_value;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    saturated;
  } rsp_t;

  typedef struct packed {
    state_word_t value;
    logic        hit;
  } sat_state_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    hit;
  } sat_out_t;

  function automatic sat_state_t sat_state(acc_t a);
    sat_state_t r;
    r.hit = 1'b1;
    if (a > ST_HI) begin
      r.value = STATE_WIDTH'(ST_HI);
    end else if (a < ST_LO) begin
      r.value = STATE_WIDTH'(ST_LO);
    end else begin
      r.value = STATE_WIDTH'(a);
      r.hit   = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_out_t sat_out(state_word_t x);
    sat_out_t  r;
    sat_word_t w;
    w     = SAT_W'(x);
    r.hit = 1'b1;
    if (w > OUT_HI) begin
      r.value = OUT_W'(OUT_HI);
    end else if (w < OUT_LO) begin
      r.value = OUT_W'(OUT_LO);
    end else begin
      r.value = OUT_W'(w);
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/cbq_serial_mul.sv =====
// ----------------------------------------------------------------------------
// cbq_serial_mul
// Bit-serial signed multiplier: one coefficient bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cbq_serial_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cbq_pkg::state_word_t mcand,
  input  cbq_pkg::coef_t       coef,
  output logic                 done,
  output cbq_pkg::prod_t       product
);

  localparam logic [cbq_pkg::MCNT_W-1:0] LAST_BIT = cbq_pkg::MCNT_W'(cbq_pkg::COEF_W - 1);

  cbq_pkg::prod_t               mc;
  cbq_pkg::coef_t               cf;
  logic [cbq_pkg::MCNT_W-1:0]   cnt;
  logic                         run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // two's complement: the top coefficient bit carries negative weight
  always_ff @(posedge clk) begin
    if (start) begin
      mc      <= cbq_pkg::PROD_W'(mcand);
      cf      <= coef;
      product <= '0;
    end else if (run) begin
      if (cf[0]) begin
        product <= (cnt == LAST_BIT) ? product - mc : product + mc;
      end
      mc <= mc <<< 1;
      cf <= cf >> 1;
    end
  end

endmodule

// ===== sv/cascaded_biquad_iir.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_iir
// Direct-form-II biquad cascade with optional trailing first-order section.
// ----------------------------------------------------------------------------
// One shared bit-serial multiplier does every product, one coefficient bit
// per cycle, and each product also takes an operand load and an accumulate.
// A sample request runs through the active biquads (at most MAX_SECTIONS)
// and then the first-order section if it is enabled; with no stage active
// the sample passes straight through. A coefficient write produces no
// result. A finished result sits in the output register while the next
// request is accepted.
module cascaded_biquad_iir (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  cbq_pkg::req_t                     req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output cbq_pkg::rsp_t                     rsp_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cbq_pkg::state_t state, state_next;
  cbq_pkg::op_t    op;

  logic [cbq_pkg::SEC_W-1:0]   sec;
  logic                        fo_phase;
  logic [cbq_pkg::COEF_AW-1:0] cbase;
  logic                        clamp_flag;

  cbq_pkg::acc_t        acc;
  cbq_pkg::state_word_t xreg;
  cbq_pkg::state_word_t vreg;

  cbq_pkg::coef_t       coef_mem [cbq_pkg::NUM_COEFS];
  cbq_pkg::state_word_t v1 [cbq_pkg::MAX_SECTIONS];
  cbq_pkg::state_word_t v2 [cbq_pkg::MAX_SECTIONS];
  cbq_pkg::state_word_t fdelay;

  logic [cbq_pkg::NS_W-1:0] num_sections;
  logic                     first_order_enable;
  logic [cbq_pkg::NS_W-1:0] ns_eff;

  logic                        accept;
  logic                        mul_start;
  logic                        mul_done;
  logic                        rsp_load;
  cbq_pkg::prod_t              mul_product;
  cbq_pkg::state_word_t        mul_mcand;
  cbq_pkg::coef_t              mul_coef;
  logic [cbq_pkg::COEF_AW-1:0] coef_off;
  logic [cbq_pkg::COEF_AW-1:0] coef_addr;
  logic                        is_sub;
  logic                        last_op;
  logic                        mid_op;
  logic                        more_sections;
  logic                        any_stage;
  cbq_pkg::acc_t               term;
  cbq_pkg::sat_state_t         acc_sat;
  cbq_pkg::sat_out_t           out_sat;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;

  assign ns_eff = (int'(num_sections) > cbq_pkg::MAX_SECTIONS) ?
                  cbq_pkg::NS_W'(cbq_pkg::MAX_SECTIONS) : num_sections;
  assign more_sections = !fo_phase && (int'(sec) + 1 < int'(ns_eff));
  assign any_stage     = (ns_eff != '0) || first_order_enable;

  // operand selection for the current product
  always_comb begin
    coef_off  = '0;
    mul_mcand = vreg;
    case (op)
      cbq_pkg::OP_A1: begin
        coef_off  = '0;
        mul_mcand = fo_phase ? fdelay : v1[sec];
      end
      cbq_pkg::OP_A2: begin
        coef_off  = cbq_pkg::COEF_AW'(1);
        mul_mcand = v2[sec];
      end
      cbq_pkg::OP_B0: begin
        coef_off  = fo_phase ? cbq_pkg::COEF_AW'(1) : cbq_pkg::COEF_AW'(2);
        mul_mcand = vreg;
      end
      cbq_pkg::OP_B1: begin
        coef_off  = fo_phase ? cbq_pkg::COEF_AW'(2) : cbq_pkg::COEF_AW'(3);
        mul_mcand = fo_phase ? fdelay : v1[sec];
      end
      cbq_pkg::OP_B2: begin
        coef_off  = cbq_pkg::COEF_AW'(4);
        mul_mcand = v2[sec];
      end
      default: begin
        coef_off  = '0;
        mul_mcand = vreg;
      end
    endcase
  end

  assign coef_addr = cbase + coef_off;
  assign mul_coef  = coef_mem[coef_addr];
  assign is_sub    = (op == cbq_pkg::OP_A1) || (op == cbq_pkg::OP_A2);
  assign last_op   = fo_phase ? (op == cbq_pkg::OP_B1) : (op == cbq_pkg::OP_B2);
  assign mid_op    = fo_phase ? (op == cbq_pkg::OP_A1) : (op == cbq_pkg::OP_A2);

  // arithmetic shift floors the product
  assign term    = cbq_pkg::acc_t'(mul_product >>> cbq_pkg::COEF_FRAC_BITS);
  assign acc_sat = cbq_pkg::sat_state(acc);
  assign out_sat = cbq_pkg::sat_out(xreg);

  cbq_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .coef    (mul_coef),
    .done    (mul_done),
    .product (mul_product)
  );

  always_comb begin
    state_next = state;
    case (state)
      cbq_pkg::ST_IDLE: begin
        if (accept && (req_data.cmd == cbq_pkg::CMD_SAMPLE)) begin
          state_next = any_stage ? cbq_pkg::ST_LOAD : cbq_pkg::ST_OUT;
        end
      end
      cbq_pkg::ST_LOAD: state_next = cbq_pkg::ST_MUL;
      cbq_pkg::ST_MUL: begin
        if (mul_done) begin
          if (last_op) begin
            state_next = cbq_pkg::ST_END;
          end else if (mid_op) begin
            state_next = cbq_pkg::ST_MID;
          end else begin
            state_next = cbq_pkg::ST_LOAD;
          end
        end
      end
      cbq_pkg::ST_MID: state_next = cbq_pkg::ST_LOAD;
      cbq_pkg::ST_END: begin
        if (more_sections || (!fo_phase && first_order_enable)) begin
          state_next = cbq_pkg::ST_LOAD;
        end else begin
          state_next = cbq_pkg::ST_OUT;
        end
      end
      cbq_pkg::ST_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = cbq_pkg::ST_IDLE;
        end
      end
      default: state_next = cbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    mul_start = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      cbq_pkg::ST_IDLE: req_stall = 1'b0;
      cbq_pkg::ST_LOAD: mul_start = 1'b1;
      cbq_pkg::ST_OUT:  rsp_load  = !rsp_valid || !rsp_stall;
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= cbq_pkg::ST_IDLE;
      op                 <= cbq_pkg::OP_A1;
      sec                <= '0;
      fo_phase           <= 1'b0;
      cbase              <= '0;
      clamp_flag         <= 1'b0;
      rsp_valid          <= 1'b0;
      num_sections       <= '0;
      first_order_enable <= 1'b0;
      fdelay             <= '0;
      for (int i = 0; i < cbq_pkg::NUM_COEFS; i++) begin
        coef_mem[i] <= '0;
      end
      for (int i = 0; i < cbq_pkg::MAX_SECTIONS; i++) begin
        v1[i] <= '0;
        v2[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbq_pkg::REG_NUM_SECTIONS: num_sections <= cfg_data[cbq_pkg::NS_W-1:0];
          cbq_pkg::REG_FIRST_ORDER:  first_order_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        cbq_pkg::ST_IDLE: begin
          if (accept) begin
            if (req_data.cmd == cbq_pkg::CMD_COEF) begin
              if (int'(req_data.coef_index) < cbq_pkg::NUM_COEFS) begin
                coef_mem[cbq_pkg::COEF_AW'(req_data.coef_index)] <= req_data.coef_value;
              end
            end else begin
              clamp_flag <= 1'b0;
              op         <= cbq_pkg::OP_A1;
              sec        <= '0;
              if (ns_eff != '0) begin
                fo_phase <= 1'b0;
                cbase    <= '0;
              end else begin
                fo_phase <= 1'b1;
                cbase    <= cbq_pkg::COEF_AW'(cbq_pkg::FO_BASE);
              end
            end
          end
        end
        cbq_pkg::ST_MUL: begin
          if (mul_done && !mid_op && !last_op) begin
            case (op)
              cbq_pkg::OP_A1: op <= cbq_pkg::OP_A2;
              cbq_pkg::OP_B0: op <= cbq_pkg::OP_B1;
              cbq_pkg::OP_B1: op <= cbq_pkg::OP_B2;
              default:        op <= cbq_pkg::OP_B0;
            endcase
          end
        end
        cbq_pkg::ST_MID: begin
          clamp_flag <= clamp_flag | acc_sat.hit;
          op         <= cbq_pkg::OP_B0;
        end
        cbq_pkg::ST_END: begin
          clamp_flag <= clamp_flag | acc_sat.hit;
          op         <= cbq_pkg::OP_A1;
          if (fo_phase) begin
            fdelay <= vreg;
          end else begin
            v2[sec] <= v1[sec];
            v1[sec] <= vreg;
          end
          if (more_sections) begin
            sec   <= sec + cbq_pkg::SEC_W'(1);
            cbase <= cbase + cbq_pkg::COEF_AW'(5);
          end else if (!fo_phase && first_order_enable) begin
            fo_phase <= 1'b1;
            cbase    <= cbq_pkg::COEF_AW'(cbq_pkg::FO_BASE);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    case (state)
      cbq_pkg::ST_IDLE: begin
        if (accept) begin
          xreg <= cbq_pkg::STATE_WIDTH'(req_data.sample);
          acc  <= cbq_pkg::ACC_W'(req_data.sample);
        end
      end
      cbq_pkg::ST_MUL: begin
        if (mul_done) begin
          acc <= is_sub ? acc - term : acc + term;
        end
      end
      cbq_pkg::ST_MID: begin
        vreg <= acc_sat.value;
        acc  <= '0;
      end
      cbq_pkg::ST_END: begin
        xreg <= acc_sat.value;
        acc  <= cbq_pkg::ACC_W'(acc_sat.value);
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      rsp_data.filtered  <= out_sat.value;
      rsp_data.saturated <= clamp_flag | out_sat.hit;
    end
  end

endmodule

// ===== sv/cbq_checker.sv =====
// ----------------------------------------------------------------------------
// cbq_checker
// Port-level checks on request and result ordering for the biquad cascade.
// ----------------------------------------------------------------------------
module cbq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input cbq_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_stall
);

  logic acc_sample;
  logic acc_coef;

  assign acc_sample = req_valid && !req_stall && (req_data.cmd == cbq_pkg::CMD_SAMPLE);
  assign acc_coef   = req_valid && !req_stall && (req_data.cmd == cbq_pkg::CMD_COEF);

  // coefficient writes never produce a result
  a_coef_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (acc_coef && !rsp_valid) |=> !rsp_valid)
    else $error("result after coefficient write");

  // a sample occupies the block, no back-to-back sample request
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    acc_sample |=> req_stall)
    else $error("request accepted while sample in flight");

  // result cannot show up the cycle right after its sample
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    (acc_sample && !rsp_valid) |=> !rsp_valid)
    else $error("result too early");

  // a new result is only launched while input is held off
  a_rsp_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result launched while idle");

endmodule

bind cascaded_biquad_iir cbq_checker u_cbq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);

// ===== test/tb_cascaded_biquad_iir.sv =====
// ----------------------------------------------------------------------------
// tb_cascaded_biquad_iir
// Self-checking bench for the biquad cascade: drives sample and coefficient
// requests, predicts every filtered output with a bit-exact integer model and
// compares it against the block under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_iir;
  import cbq_pkg::*;

  localparam int SHOWN_LIMIT  = 10;
  localparam int QUIET_CYCLES = 450;      // longer than the slowest request
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 80;
  localparam int HOLD_CYCLES  = 3000;

  localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
  localparam int COEF_MAX   = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_MIN   = -(1 << (COEF_W - 1));

  // first-order section layout after the biquads
  localparam int FO_A1 = 0;
  localparam int FO_B0 = 1;
  localparam int FO_B1 = 2;

  // register indexes past the defined list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  class iir_scoreboard;
    longint biquad_delay[2 * MAX_SECTIONS];   // v1, v2 per section
    longint fo_delay;
    longint coef_store[NUM_COEFS];
    int unsigned sections;
    bit fo_on;
    rsp_t expected_outputs[$];
    int errors;

    function new();
      foreach (biquad_delay[i]) biquad_delay[i] = 0;
      foreach (coef_store[i]) coef_store[i] = 0;
      fo_delay = 0;
      sections = 0;
      fo_on    = 1'b0;
      errors   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_SECTIONS: sections = 32'(data);
        REG_FIRST_ORDER:  fo_on = data[0];
        default: ;
      endcase
    endfunction

    // Q2.14 product, floor toward minus infinity
    function longint scale(longint d, longint c);
      return (d * c) >>> COEF_FRAC_BITS;
    endfunction

    function longint clamp(longint x, int w, inout bit hit);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
        hit = 1'b1;
        return hi;
      end
      if (x < lo) begin
        hit = 1'b1;
        return lo;
      end
      return x;
    endfunction

    function rsp_t filter_sample(longint x);
      int unsigned n;
      int b;
      longint v, y, d1, d2;
      bit hit;
      rsp_t res;
      hit = 1'b0;
      n = (sections > MAX_SECTIONS) ? MAX_SECTIONS : sections;
      for (int k = 0; k < n; k++) begin
        b  = 5 * k;
        d1 = biquad_delay[2 * k];
        d2 = biquad_delay[2 * k + 1];
        v = clamp(x - scale(d1, coef_store[b + int'(OP_A1)])
                    - scale(d2, coef_store[b + int'(OP_A2)]), STATE_WIDTH, hit);
        y = scale(v, coef_store[b + int'(OP_B0)]) + scale(d1, coef_store[b + int'(OP_B1)])
          + scale(d2, coef_store[b + int'(OP_B2)]);
        biquad_delay[2 * k + 1] = d1;
        biquad_delay[2 * k]     = v;
        x = clamp(y, STATE_WIDTH, hit);
      end
      if (fo_on) begin
        v = clamp(x - scale(fo_delay, coef_store[FO_BASE + FO_A1]), STATE_WIDTH, hit);
        y = scale(v, coef_store[FO_BASE + FO_B0]) + scale(fo_delay, coef_store[FO_BASE + FO_B1]);
        fo_delay = v;
        x = clamp(y, STATE_WIDTH, hit);
      end
      x = clamp(x, OUT_W, hit);
      res.filtered  = x[OUT_W-1:0];
      res.saturated = hit;
      return res;
    endfunction

    function void note_request(req_t r);
      if (r.cmd == CMD_COEF) begin
        if (r.coef_index < NUM_COEFS) coef_store[r.coef_index] = longint'($signed(r.coef_value));
      end else begin
        expected_outputs.push_back(filter_sample(longint'($signed(r.sample))));
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_outputs.size() == 0) begin
        errors++;
        if (errors <= SHOWN_LIMIT)
          $display("unexpected result: filtered=%0d saturated=%0b", got.filtered, got.saturated);
        return;
      end
      want = expected_outputs.pop_front();
      if (got.filtered !== want.filtered || got.saturated !== want.saturated) begin
        errors++;
        if (errors <= SHOWN_LIMIT)
          $display("mismatch: expected filtered=%0d saturated=%0b, got filtered=%0d saturated=%0b",
                   want.filtered, want.saturated, got.filtered, got.saturated);
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct = 33;
  int recv_idle_pct = 71;
  int rsp_hold_left = 0;
  int unsigned cycle_count = 0;
  iir_scoreboard sb = new();

  cascaded_biquad_iir uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int srand(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic req_t coef_req(int idx, int val);
    req_t r;
    r.cmd        = CMD_COEF;
    r.sample     = SAMPLE_W'($urandom);
    r.coef_index = COEF_IDX_W'(idx);
    r.coef_value = COEF_W'(val);
    return r;
  endfunction

  function automatic req_t sample_req(int s);
    req_t r;
    r.cmd        = CMD_SAMPLE;
    r.sample     = SAMPLE_W'(s);
    r.coef_index = COEF_IDX_W'($urandom);
    r.coef_value = COEF_W'($urandom);
    return r;
  endfunction

  function automatic req_t random_item();
    int s;
    if ($urandom_range(9) == 0)
      return coef_req($urandom_range(31),
                      ($urandom_range(3) == 0) ? int'($urandom_range(0, 65535)) + COEF_MIN
                                               : srand(2000));
    case ($urandom_range(9))
      0:       s = SAMPLE_MIN;
      1:       s = SAMPLE_MAX;
      2:       s = srand(16);
      default: s = int'($urandom_range(0, 4095)) + SAMPLE_MIN;
    endcase
    return sample_req(s);
  endfunction

  task automatic push_req(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      // now and then a gap long enough to land mid-computation
      if ($urandom_range(15) == 0) repeat ($urandom_range(1, QUIET_CYCLES)) @(posedge clk);
      else @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  // cfg_valid is left high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  // coefficient writes give no result, so give the block time to go idle
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int ns, bit fo);
    write_reg(REG_NUM_SECTIONS, CFG_DATA_W'(ns));
    write_reg(REG_FIRST_ORDER, CFG_DATA_W'({$urandom_range(3), fo}));
    if ($urandom_range(1) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stable sets keep |a2| < 1 and |a1| < 1 + a2; wild sets are fully random
  task automatic load_coefs(bit wild);
    int a2_next;
    int val;
    a2_next = 0;
    for (int i = 0; i < NUM_COEFS; i++) begin
      if (wild) begin
        val = int'($urandom_range(0, 65535)) + COEF_MIN;
      end else if (i >= FO_BASE) begin
        val = (i == FO_BASE + FO_A1) ? srand(14000) : srand(16384);
      end else begin
        case (i % 5)
          OP_A1: begin
            a2_next = srand(12000);
            val = srand((16384 + a2_next) * 9 / 10);
          end
          OP_A2:   val = a2_next;
          default: val = srand(16384);
        endcase
      end
      push_req(coef_req(i, val));
    end
  endtask

  // response side: check accepted results, then pick next cycle's stall
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (rsp_hold_left > 0) begin
        rsp_stall <= 1'b1;
        rsp_hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL cascaded_biquad_iir");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no section enabled: samples pass straight through
    push_req(sample_req(SAMPLE_MIN));
    push_req(sample_req(SAMPLE_MAX));
    push_req(sample_req(0));
    push_req(sample_req(-1));
    // coefficient index past the store is dropped
    push_req(coef_req(NUM_COEFS, COEF_MAX));
    push_req(coef_req(31, COEF_MIN));
    settle();

    // section count above the maximum, writes to unused register indexes
    write_reg(REG_NUM_SECTIONS, CFG_DATA_W'(7));
    write_reg(REG_FIRST_ORDER, CFG_DATA_W'(1));
    write_reg(REG_SPARE_A, CFG_DATA_W'(0));
    write_reg(REG_SPARE_B, CFG_DATA_W'(5));
    cfg_valid <= 1'b0;

    // a1 = -2.0 makes section 0 diverge into its rails
    push_req(coef_req(int'(OP_A1), COEF_MIN));
    push_req(coef_req(int'(OP_B0), COEF_MAX));
    push_req(coef_req(FO_BASE + FO_A1, COEF_MAX));
    repeat (12) push_req(sample_req(SAMPLE_MAX));
    repeat (2) push_req(sample_req(SAMPLE_MIN));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 33;
      end
      if (seg == 2 * SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long output hold-off while requests keep coming: the block backs up
        settle();
        configure(MAX_SECTIONS, 1'b1);
        load_coefs(1'b0);
        rsp_hold_left = HOLD_CYCLES;
        repeat (16) push_req(random_item());
      end
      settle();
      configure((seg * 3) % 8, seg % 2);
      load_coefs(seg % 4 == 3);
      repeat (SEG_ITEMS) push_req(random_item());
    end

    req_valid <= 1'b0;
    for (int w = 0; w < 20000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS cascaded_biquad_iir");
    end else begin
      $display("FAIL cascaded_biquad_iir");
    end
    $finish;
  end

endmodule
